>>> src/sch_pkg.sv
// package with shared types and constants of the sparse coordinate bin histogram
`timescale 1ns / 1ps
package sch_pkg;

  localparam int CntW  = 32;
  localparam int CoordW = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BIN_ROWS     = 3'd0,
    REG_BIN_COLS     = 3'd1,
    REG_ROW_RATE     = 3'd2,
    REG_COL_RATE     = 3'd3,
    REG_IS_SYMMETRIC = 3'd4,
    REG_IS_COMPLEX   = 3'd5
  } sch_reg_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } sch_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_RD,
    ST_WR,
    ST_RES
  } sch_state_e;

  typedef struct packed {
    logic              operation;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              real_nonzero;
    logic              imag_nonzero;
  } sch_in_t;

  typedef struct packed {
    logic [5:0]      bin_row;
    logic [5:0]      bin_col;
    logic [CntW-1:0] real_count;
    logic [CntW-1:0] imag_count;
    logic [CntW-1:0] total_count;
    logic            present;
    logic            mirror;
  } sch_out_t;

  typedef struct packed {
    logic            touched;
    logic [CntW-1:0] total_cnt;
    logic [CntW-1:0] imag_cnt;
    logic [CntW-1:0] real_cnt;
  } sch_entry_t;

  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] dividend;
    logic [CoordW-1:0] divisor;
  } sch_div_req_t;

  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] quotient;
  } sch_div_rsp_t;

  function automatic logic [CntW-1:0] sat_add(logic [CntW-1:0] a, logic [1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {{(CntW-1){1'b0}}, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

endpackage

>>> src/sch_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sch_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sch_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sch_pkg::sch_div_req_t req_i,
  output sch_pkg::sch_div_rsp_t rsp_o
);
  import sch_pkg::*;

  localparam int CntBits = $clog2(CoordW);

  logic [CoordW-1:0]  rem_q, rem_d;
  logic [CoordW-1:0]  quo_q, quo_d;
  logic [CoordW-1:0]  dvs_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CoordW:0]    trial;

  always_comb begin
    trial  = {rem_q, quo_q[CoordW-1]} - {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = trial[CoordW] ? {rem_q[CoordW-2:0], quo_q[CoordW-1]} : trial[CoordW-1:0];
      quo_d = {quo_q[CoordW-2:0], ~trial[CoordW]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {CntBits{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> src/sparse_coordinate_bin_histogram_unit.sv
// top level of the sparse coordinate bin histogram
`timescale 1ns / 1ps
// Bins sparse matrix coordinates into a grid of counters held in one ram of
// MAX_BIN_ROWS*MAX_BIN_COLS entries. After reset a clearing pass writes every
// entry once, one per cycle, and the input stalls until the pass is done;
// configuration writes are taken meanwhile. An add word runs two 32-step
// divisions one after the other on the shared radix-2 divider and then a
// read-modify-write of the ram. A read word does one ram read and then a load
// of the output register; the load waits while a stalled result still holds
// the output register. One word is worked on at a time.
module sparse_coordinate_bin_histogram_unit #(
  parameter int MAX_BIN_ROWS = 64,
  parameter int MAX_BIN_COLS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sch_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sch_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sch_pkg::sch_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sch_pkg::sch_out_t             out_data_o
);
  import sch_pkg::*;

  localparam int Depth = MAX_BIN_ROWS * MAX_BIN_COLS;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RW = (MAX_BIN_ROWS > 1) ? $clog2(MAX_BIN_ROWS) : 1;
  localparam int CW = (MAX_BIN_COLS > 1) ? $clog2(MAX_BIN_COLS) : 1;

  // configuration registers
  logic [6:0]        bin_rows_q, bin_cols_q;
  logic [CoordW-1:0] row_rate_q, col_rate_q;
  logic              is_sym_q, is_cplx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_rows_q <= 7'd64;
      bin_cols_q <= 7'd64;
      row_rate_q <= 32'd1;
      col_rate_q <= 32'd1;
      is_sym_q   <= 1'b0;
      is_cplx_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BIN_ROWS:     bin_rows_q <= cfg_data_i[6:0];
        REG_BIN_COLS:     bin_cols_q <= cfg_data_i[6:0];
        REG_ROW_RATE:     row_rate_q <= cfg_data_i;
        REG_COL_RATE:     col_rate_q <= cfg_data_i;
        REG_IS_SYMMETRIC: is_sym_q   <= cfg_data_i[0];
        REG_IS_COMPLEX:   is_cplx_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // last valid bin on each axis
  logic [RW-1:0] last_row;
  logic [CW-1:0] last_col;

  always_comb begin
    if (bin_rows_q == 7'd0) begin
      last_row = '0;
    end else if (32'(bin_rows_q) > 32'(MAX_BIN_ROWS)) begin
      last_row = RW'(MAX_BIN_ROWS - 1);
    end else begin
      last_row = RW'(bin_rows_q - 7'd1);
    end
    if (bin_cols_q == 7'd0) begin
      last_col = '0;
    end else if (32'(bin_cols_q) > 32'(MAX_BIN_COLS)) begin
      last_col = CW'(MAX_BIN_COLS - 1);
    end else begin
      last_col = CW'(bin_cols_q - 7'd1);
    end
  end

  sch_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;
  logic          in_acc, out_acc;

  sch_in_t       item_q;
  logic [RW-1:0] bi_q;
  logic [CW-1:0] bj_q;
  logic          inr_q;
  sch_out_t      out_q;

  sch_div_req_t div_req;
  sch_div_rsp_t div_rsp;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_addr;
  sch_entry_t    ram_wdata, ram_rdata, upd;
  logic [1:0]    cnt;
  logic          load_bi, load_bj, load_rd, load_out;
  logic [RW-1:0] bi_clamp;
  logic [CW-1:0] bj_clamp;
  sch_out_t      res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  assign ram_addr = AW'(32'(bi_q) * 32'(MAX_BIN_COLS) + 32'(bj_q));

  assign bi_clamp = (div_rsp.quotient > 32'(last_row)) ? last_row
                                                       : div_rsp.quotient[RW-1:0];
  assign bj_clamp = (div_rsp.quotient > 32'(last_col)) ? last_col
                                                       : div_rsp.quotient[CW-1:0];

  // counter update for an add word
  always_comb begin
    cnt = (is_sym_q && (32'(bi_q) == 32'(bj_q)) && (item_q.row != item_q.col)) ? 2'd2
                                                                             : 2'd1;
    upd = ram_rdata;
    upd.touched = 1'b1;
    if (!is_cplx_q) begin
      upd.real_cnt = sat_add(ram_rdata.real_cnt, cnt);
    end else begin
      if (item_q.real_nonzero) begin
        upd.real_cnt = sat_add(ram_rdata.real_cnt, cnt);
      end
      if (item_q.imag_nonzero) begin
        upd.imag_cnt = sat_add(ram_rdata.imag_cnt, cnt);
      end
      upd.total_cnt = sat_add(ram_rdata.total_cnt, cnt);
    end
  end

  // result of a read word
  always_comb begin
    res.bin_row     = item_q.row[5:0];
    res.bin_col     = item_q.col[5:0];
    res.real_count  = '0;
    res.imag_count  = '0;
    res.total_count = '0;
    res.present     = 1'b0;
    res.mirror      = 1'b0;
    if (inr_q) begin
      res.real_count  = ram_rdata.real_cnt;
      res.imag_count  = is_cplx_q ? ram_rdata.imag_cnt : '0;
      res.total_count = is_cplx_q ? ram_rdata.total_cnt : '0;
      res.present     = ram_rdata.touched;
      res.mirror      = is_sym_q && ram_rdata.touched && (item_q.row != item_q.col);
    end
  end

  always_comb begin
    state_d          = state_q;
    clr_d            = clr_q;
    out_valid_d      = out_valid_q && !out_acc;
    div_req.start    = 1'b0;
    div_req.dividend = item_q.row;
    div_req.divisor  = (row_rate_q == '0) ? 32'd1 : row_rate_q;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = ram_addr;
    ram_wdata        = upd;
    load_bi          = 1'b0;
    load_bj          = 1'b0;
    load_rd          = 1'b0;
    load_out         = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.operation == OP_ADD) begin
            div_req.start    = 1'b1;
            div_req.dividend = in_data_i.row;
            state_d          = ST_DIV_ROW;
          end else begin
            load_rd = 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_DIV_ROW: begin
        if (div_rsp.done) begin
          load_bi          = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = item_q.col;
          div_req.divisor  = (col_rate_q == '0) ? 32'd1 : col_rate_q;
          state_d          = ST_DIV_COL;
        end
      end
      ST_DIV_COL: begin
        if (div_rsp.done) begin
          load_bj = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = (item_q.operation == OP_ADD) ? ST_WR : ST_RES;
      end
      ST_WR: begin
        ram_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if (load_rd) begin
      bi_q  <= in_data_i.row[RW-1:0];
      bj_q  <= in_data_i.col[CW-1:0];
      inr_q <= (in_data_i.row <= 32'(last_row)) && (in_data_i.col <= 32'(last_col));
    end
    if (load_bi) begin
      bi_q <= bi_clamp;
    end
    if (load_bj) begin
      bj_q <= bj_clamp;
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  sch_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sch_ram #(
    .WIDTH ($bits(sch_entry_t)),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_ROW || state_q == ST_DIV_COL))
    else $error("divider finished outside a division step");

  a_bin_on_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD && item_q.operation == OP_ADD) |->
      (32'(bi_q) <= 32'(last_row) && 32'(bj_q) <= 32'(last_col)))
    else $error("add word binned outside the grid");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> ($past(state_q) == ST_RD))
    else $error("counter write without a preceding read");
`endif

endmodule

>>> tb/sch_checker.sv
// checker that predicts and compares the result words of the sparse coordinate bin histogram
`timescale 1ns / 1ps
module sch_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sch_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sch_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  sch_pkg::sch_in_t             in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  sch_pkg::sch_out_t            out_data_i,
  output int                           err_cnt_o,
  output int                           pending_o
);
  import sch_pkg::*;

  localparam int MaxRows  = 64;
  localparam int MaxCols  = 64;
  localparam int GridSize = MaxRows * MaxCols;

  logic [CntW-1:0] real_cnt  [GridSize];
  logic [CntW-1:0] imag_cnt  [GridSize];
  logic [CntW-1:0] total_cnt [GridSize];
  bit              touched   [GridSize];

  logic [6:0]  rows_q, cols_q;
  logic [31:0] row_rate_q, col_rate_q;
  logic        sym_q, cplx_q;

  sch_out_t reads_due [$];
  int       errs;

  function automatic logic [31:0] eff_bins(logic [6:0] v, int maxv);
    if (v == 0) return 32'd1;
    if (v > maxv) return 32'(maxv);
    return 32'(v);
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] a, logic [1:0] inc);
    logic [CntW:0] s;
    s = {1'b0, a} + (CntW+1)'(inc);
    return s[CntW] ? '1 : s[CntW-1:0];
  endfunction

  task automatic take_word(input sch_in_t w);
    logic [31:0] nr, nc, rr, cr, bi, bj, idx;
    logic [1:0]  inc;
    sch_out_t    res;
    nr = eff_bins(rows_q, MaxRows);
    nc = eff_bins(cols_q, MaxCols);
    if (w.operation == OP_ADD) begin
      rr = (row_rate_q == 0) ? 32'd1 : row_rate_q;
      cr = (col_rate_q == 0) ? 32'd1 : col_rate_q;
      bi = w.row / rr;
      bj = w.col / cr;
      if (bi > nr - 1) bi = nr - 1;
      if (bj > nc - 1) bj = nc - 1;
      // off-diagonal element landing in a diagonal bin stands for its mirror too
      inc = (sym_q && bi == bj && w.row != w.col) ? 2'd2 : 2'd1;
      idx = bi * MaxCols + bj;
      if (!cplx_q) begin
        real_cnt[idx] = sat_inc(real_cnt[idx], inc);
      end else begin
        if (w.real_nonzero) real_cnt[idx] = sat_inc(real_cnt[idx], inc);
        if (w.imag_nonzero) imag_cnt[idx] = sat_inc(imag_cnt[idx], inc);
        total_cnt[idx] = sat_inc(total_cnt[idx], inc);
      end
      touched[idx] = 1'b1;
    end else begin
      res = '0;
      res.bin_row = w.row[5:0];
      res.bin_col = w.col[5:0];
      if (w.row < nr && w.col < nc) begin
        idx = w.row * MaxCols + w.col;
        res.real_count  = real_cnt[idx];
        res.imag_count  = cplx_q ? imag_cnt[idx] : '0;
        res.total_count = cplx_q ? total_cnt[idx] : '0;
        res.present     = touched[idx];
        res.mirror      = sym_q && touched[idx] && (w.row != w.col);
      end
      reads_due.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endtask

  task automatic match_result(input sch_out_t got);
    sch_out_t want;
    if (reads_due.size() == 0) begin
      $error("result word with no read waiting: bin_row %0d bin_col %0d",
             got.bin_row, got.bin_col);
      errs++;
    end else begin
      want = reads_due.pop_front();
      check_field("bin_row", 32'(want.bin_row), 32'(got.bin_row));
      check_field("bin_col", 32'(want.bin_col), 32'(got.bin_col));
      check_field("real_count", want.real_count, got.real_count);
      check_field("imag_count", want.imag_count, got.imag_count);
      check_field("total_count", want.total_count, got.total_count);
      check_field("present", 32'(want.present), 32'(got.present));
      check_field("mirror", 32'(want.mirror), 32'(got.mirror));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GridSize; i++) begin
        real_cnt[i]  = '0;
        imag_cnt[i]  = '0;
        total_cnt[i] = '0;
        touched[i]   = 1'b0;
      end
      rows_q     = 7'd64;
      cols_q     = 7'd64;
      row_rate_q = 32'd1;
      col_rate_q = 32'd1;
      sym_q      = 1'b0;
      cplx_q     = 1'b0;
      reads_due.delete();
      errs       = 0;
    end else begin
      if (cfg_we_i) begin
        case (sch_reg_e'(cfg_idx_i))
          REG_BIN_ROWS:     rows_q = cfg_data_i[6:0];
          REG_BIN_COLS:     cols_q = cfg_data_i[6:0];
          REG_ROW_RATE:     row_rate_q = cfg_data_i;
          REG_COL_RATE:     col_rate_q = cfg_data_i;
          REG_IS_SYMMETRIC: sym_q = cfg_data_i[0];
          REG_IS_COMPLEX:   cplx_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) match_result(out_data_i);
      if (in_valid_i && !in_stall_i) take_word(in_data_i);
    end
    err_cnt_o <= errs;
    pending_o <= reads_due.size();
  end

endmodule

>>> tb/tb_sparse_coordinate_bin_histogram_unit.sv
// testbench top that drives the sparse coordinate bin histogram and reports the verdict
`timescale 1ns / 1ps
module tb_sparse_coordinate_bin_histogram_unit;
  import sch_pkg::*;

  localparam int PhaseItems = 210;
  localparam int PushItems  = 24;
  localparam int HoldCycles = 400;
  localparam int Settle     = 150;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  sch_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  sch_out_t            out_data_o;

  int err_cnt;
  int exp_pending;
  bit hold_go;
  bit hold_done;

  int unsigned g_rows, g_cols;
  logic [31:0] g_rrate, g_crate;
  logic [11:0] hot_bins [$];

  sparse_coordinate_bin_histogram_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  sch_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_i (out_data_o),
    .err_cnt_o  (err_cnt),
    .pending_o  (exp_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic sch_in_t mk_word(sch_op_e op, logic [31:0] r, logic [31:0] c,
                                      logic re, logic im);
    sch_in_t w;
    w.operation    = op;
    w.row          = r;
    w.col          = c;
    w.real_nonzero = re;
    w.imag_nonzero = im;
    return w;
  endfunction

  function automatic int unsigned eff_n(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return 32'(v);
  endfunction

  task automatic put_reg(input sch_reg_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [6:0] rows, input logic [6:0] cols,
                          input logic [31:0] rrate, input logic [31:0] crate,
                          input logic sym, input logic cplx);
    put_reg(REG_BIN_ROWS, 32'(rows));
    put_reg(REG_BIN_COLS, 32'(cols));
    put_reg(REG_ROW_RATE, rrate);
    put_reg(REG_COL_RATE, crate);
    put_reg(REG_IS_SYMMETRIC, 32'(sym));
    put_reg(REG_IS_COMPLEX, 32'(cplx));
    cfg_we_i <= 1'b0;
    g_rows  = eff_n(rows);
    g_cols  = eff_n(cols);
    g_rrate = (rrate == 0) ? 32'd1 : rrate;
    g_crate = (crate == 0) ? 32'd1 : crate;
  endtask

  task automatic push_word(input sch_in_t w, input bit gaps);
    int unsigned p, n;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (gaps) begin
      p = $urandom_range(0, 99);
      n = 0;
      if (p >= 90) n = $urandom_range(8, 50);
      else if (p >= 55) n = $urandom_range(1, 3);
      if (n > 0) begin
        in_valid_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  endtask

  // wait for every read result, then let a trailing add finish
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_pending != 0);
    repeat (Settle) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord(int unsigned n, logic [31:0] rate);
    logic [63:0] span;
    int unsigned p;
    span = 64'(n) * 64'(rate) + 64'(rate);
    p = $urandom_range(0, 9);
    if (p < 7) begin
      if (span > 64'hFFFF_FFFF) return $urandom();
      return $urandom_range(0, 32'(span - 1));
    end
    if (p < 9) return $urandom();
    return 32'hFFFF_FFFF - $urandom_range(0, 3);
  endfunction

  function automatic sch_in_t rand_add();
    logic [31:0] r, c, bi, bj;
    int unsigned p;
    r = pick_coord(g_rows, g_rrate);
    p = $urandom_range(0, 3);
    if (p == 0) c = r;
    else if (p == 1) c = r + $urandom_range(1, 3);
    else c = pick_coord(g_cols, g_crate);
    bi = r / g_rrate;
    bj = c / g_crate;
    if (bi > g_rows - 1) bi = g_rows - 1;
    if (bj > g_cols - 1) bj = g_cols - 1;
    hot_bins.push_back({bi[5:0], bj[5:0]});
    if (hot_bins.size() > 64) void'(hot_bins.pop_front());
    return mk_word(OP_ADD, r, c, 1'($urandom), 1'($urandom));
  endfunction

  function automatic sch_in_t rand_read();
    logic [31:0] r, c;
    logic [11:0] b;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60 && hot_bins.size() > 0) begin
      b = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
      // swapped coordinates hit the mirror position
      if (p < 52) begin
        r = 32'(b[11:6]);
        c = 32'(b[5:0]);
      end else begin
        r = 32'(b[5:0]);
        c = 32'(b[11:6]);
      end
    end else if (p < 90) begin
      r = $urandom_range(0, g_rows);
      c = $urandom_range(0, g_cols);
    end else begin
      r = $urandom();
      c = $urandom();
    end
    return mk_word(OP_READ, r, c, 1'($urandom), 1'($urandom));
  endfunction

  function automatic sch_in_t rand_word(int unsigned read_pct);
    if ($urandom_range(0, 99) < read_pct) return rand_read();
    return rand_add();
  endfunction

  // receiver side stalls
  initial begin
    int unsigned p, n;
    logic v;
    out_stall_i <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_go && !hold_done) begin
        v = 1'b1;
        n = HoldCycles;
        hold_done = 1'b1;
      end else begin
        p = $urandom_range(0, 99);
        if (p < 50) begin
          v = 1'b0;
          n = $urandom_range(1, 4);
        end else if (p < 65) begin
          v = 1'b0;
          n = $urandom_range(30, 120);
        end else if (p < 95) begin
          v = 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          v = 1'b1;
          n = $urandom_range(10, 60);
        end
      end
      out_stall_i <= v;
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin
    logic [6:0]  t_rows  [6] = '{7'd64, 7'd1, 7'd0, 7'd16, 7'd64, 7'd33};
    logic [6:0]  t_cols  [6] = '{7'd64, 7'd1, 7'd127, 7'd20, 7'd64, 7'd64};
    logic [31:0] t_rrate [6] = '{32'd1, 32'hFFFF_FFFF, 32'd5, 32'd4, 32'h0400_0000, 32'd2};
    logic [31:0] t_crate [6] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd7, 32'h0400_0000, 32'd1};
    logic        t_sym   [6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    logic        t_cplx  [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_BIN_ROWS;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    hold_go     <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: clipping, diagonal doubling, flags, reads off the grid
    set_grid(7'd8, 7'd100, 32'd0, 32'd3, 1'b1, 1'b1);
    push_word(mk_word(OP_ADD, 32'd0, 32'd0, 1'b1, 1'b1), 1'b0);
    push_word(mk_word(OP_ADD, 32'd0, 32'd1, 1'b1, 1'b0), 1'b0);
    push_word(mk_word(OP_ADD, 32'd5, 32'd16, 1'b0, 1'b1), 1'b0);
    push_word(mk_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0);
    push_word(mk_word(OP_ADD, 32'd3, 32'd200, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_ADD, 32'd7, 32'd21, 1'b1, 1'b1), 1'b0);
    push_word(mk_word(OP_READ, 32'd0, 32'd0, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_READ, 32'd5, 32'd5, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_READ, 32'd7, 32'd63, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_READ, 32'd3, 32'd63, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_READ, 32'd8, 32'd0, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_READ, 32'd0, 32'd64, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0);
    push_word(mk_word(OP_READ, 32'd1, 32'd2, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_READ, 32'd7, 32'd7, 1'b0, 1'b0), 1'b0);
    drain();

    // real mode hides the imaginary and total counts
    set_grid(7'd8, 7'd100, 32'd0, 32'd3, 1'b1, 1'b0);
    push_word(mk_word(OP_READ, 32'd0, 32'd0, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_ADD, 32'd0, 32'd0, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_READ, 32'd0, 32'd0, 1'b0, 1'b0), 1'b0);
    drain();

    // zero bin rows acts as one, back in complex mode
    set_grid(7'd0, 7'd1, 32'd1, 32'd0, 1'b0, 1'b1);
    push_word(mk_word(OP_ADD, 32'd12345, 32'd9, 1'b1, 1'b1), 1'b0);
    push_word(mk_word(OP_READ, 32'd0, 32'd0, 1'b0, 1'b0), 1'b0);
    push_word(mk_word(OP_READ, 32'd1, 32'd0, 1'b0, 1'b0), 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_grid(t_rows[ph], t_cols[ph], t_rrate[ph], t_crate[ph], t_sym[ph], t_cplx[ph]);
      if (ph == 2) begin
        // hold the output off while reads pile up at the input
        hold_go <= 1'b1;
        for (int i = 0; i < PushItems; i++) push_word(rand_word(75), 1'b0);
      end
      for (int i = 0; i < PhaseItems; i++) push_word(rand_word(35), (i % 64) >= 16);
      drain();
    end

    if (err_cnt == 0 && exp_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sparse_coordinate_bin_histogram_unit.f
src/sch_pkg.sv
src/sch_ram.sv
src/sch_div.sv
src/sparse_coordinate_bin_histogram_unit.sv
tb/sch_checker.sv
tb/tb_sparse_coordinate_bin_histogram_unit.sv
